@@ hdl/quaternion_to_yaw_pitch_roll_defines.svh @@
// Assertion macros for the checker file qtypr_checker.sv.
`ifndef QUATERNION_TO_YAW_PITCH_ROLL_DEFINES_SVH
`define QUATERNION_TO_YAW_PITCH_ROLL_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define QTYPR_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define QTYPR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define QTYPR_ASSERT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/qtypr_pkg.sv @@
package qtypr_pkg;

   localparam int unsigned MAX_STEPS   = 32;
   localparam int unsigned ROOT_BITS   = 31;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned G_BITS      = 32;
   localparam int unsigned ABS_BITS    = 31;
   localparam int unsigned SQ_BITS     = 64;
   localparam int unsigned YN_BITS     = 34;
   localparam int unsigned TILT_W      = 35;

   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

   // atan(2^-i), full circle = 2^32
   localparam logic [31:0] ATAN_TAB [MAX_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic full;
      logic empty;
   } qtypr_q_status_type;

endpackage

@@ hdl/qtypr_req_if.sv @@
interface qtypr_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] quat_w;
   logic signed [15:0] quat_x;
   logic signed [15:0] quat_y;
   logic signed [15:0] quat_z;

   modport source (output valid, output quat_w, output quat_x, output quat_y,
                   output quat_z, input ready);
   modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                   input quat_z, output ready);
endinterface

@@ hdl/qtypr_rsp_if.sv @@
interface qtypr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] yaw_angle;
   logic signed [15:0] pitch_angle;
   logic signed [15:0] roll_angle;

   modport source (output valid, output yaw_angle, output pitch_angle,
                   output roll_angle, input ready);
   modport sink   (input valid, input yaw_angle, input pitch_angle,
                   input roll_angle, output ready);
endinterface

@@ hdl/quaternion_to_yaw_pitch_roll.sv @@
// Channel   Direction  Word
// req_bus   in         quat_w, quat_x, quat_y, quat_z (signed Q1.14, 16 bits each)
// rsp_bus   out        yaw_angle, pitch_angle, roll_angle (signed, 32768 = pi)
//
// One word in and out per cycle once the pipeline is full and rsp_bus is ready.
// Words pass 4 front stages, the queue, 31 root stages (one bit per stage)
// and the CORDIC pre-rotation, step (one per stage) and output registers.
// Reset is synchronous and active high; it empties the pipeline and the queue.
// A stalled rsp_bus freezes the back end; the front keeps taking words until
// the four-word queue fills, then drops req_bus.ready.
module quaternion_to_yaw_pitch_roll #(
   parameter int QUAT_FRAC_BITS = 14,
   parameter int ANGLE_BITS     = 16,
   parameter int CORDIC_STEPS   = 16
) (
   input  logic         clock,
   input  logic         reset,
   qtypr_req_if.sink    req_bus,
   qtypr_rsp_if.source  rsp_bus
);
   // yaw denominator holds 2ww + 2xx - 1.0 with 1.0 at 2*QUAT_FRAC_BITS
   localparam int YD_BITS = (2 * QUAT_FRAC_BITS + 2 > 35) ? 2 * QUAT_FRAC_BITS + 2 : 35;
   localparam int YAW_W   = YD_BITS + 3;
   localparam int TW      = qtypr_pkg::TILT_W;
   localparam int GB      = qtypr_pkg::G_BITS;
   localparam int NB      = qtypr_pkg::YN_BITS;
   localparam int SB      = qtypr_pkg::SQ_BITS;
   localparam int RB      = qtypr_pkg::ROOT_BITS;
   localparam int QW      = 2 * GB + NB + YD_BITS + 2 * SB;

   logic                  front_en, back_en;
   logic                  f_valid;
   logic signed [GB-1:0]  f_gx, f_gy, b_gx, b_gy, m_gx, m_gy;
   logic signed [NB-1:0]  f_yn, b_yn, m_yn;
   logic signed [YD_BITS-1:0] f_yd, b_yd, m_yd;
   logic [SB-1:0]         f_sp, f_sr, b_sp, b_sr;
   logic [QW-1:0]         q_out;
   qtypr_pkg::qtypr_q_status_type q_stat;
   logic                  m_valid;
   logic [RB-1:0]         m_mp, m_mr;
   logic                  yaw_v, pitch_v, roll_v;

   // front advances while the queue has room
   assign front_en      = !q_stat.full;
   assign req_bus.ready = front_en;

   qtypr_front #(
      .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
      .YD_BITS        (YD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (front_en),
      .in_valid  (req_bus.valid),
      .quat_w    (req_bus.quat_w),
      .quat_x    (req_bus.quat_x),
      .quat_y    (req_bus.quat_y),
      .quat_z    (req_bus.quat_z),
      .out_valid (f_valid),
      .gx        (f_gx),
      .gy        (f_gy),
      .yn        (f_yn),
      .yd        (f_yd),
      .sp        (f_sp),
      .sr        (f_sr)
   );

   qtypr_queue #(.W(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid && front_en),
      .push_data ({f_gx, f_gy, f_yn, f_yd, f_sp, f_sr}),
      .pop       (back_en && !q_stat.empty),
      .pop_data  (q_out),
      .status    (q_stat)
   );

   assign {b_gx, b_gy, b_yn, b_yd, b_sp, b_sr} = q_out;

   // back end moves as one while the output word is empty or being taken
   assign back_en = !rsp_bus.valid || rsp_bus.ready;

   qtypr_mag #(.YD_BITS(YD_BITS)) u_mag (
      .clock     (clock),
      .reset     (reset),
      .en        (back_en),
      .in_valid  (!q_stat.empty),
      .in_gx     (b_gx),
      .in_gy     (b_gy),
      .in_yn     (b_yn),
      .in_yd     (b_yd),
      .in_sp     (b_sp),
      .in_sr     (b_sr),
      .out_valid (m_valid),
      .out_gx    (m_gx),
      .out_gy    (m_gy),
      .out_yn    (m_yn),
      .out_yd    (m_yd),
      .out_mp    (m_mp),
      .out_mr    (m_mr)
   );

   qtypr_cordic #(
      .W (YAW_W), .ANGLE_BITS (ANGLE_BITS), .CORDIC_STEPS (CORDIC_STEPS)
   ) u_yaw (
      .clock     (clock),
      .reset     (reset),
      .en        (back_en),
      .in_valid  (m_valid),
      .in_y      (YAW_W'(m_yn)),
      .in_x      (YAW_W'(m_yd)),
      .out_valid (yaw_v),
      .angle     (rsp_bus.yaw_angle)
   );

   qtypr_cordic #(
      .W (TW), .ANGLE_BITS (ANGLE_BITS), .CORDIC_STEPS (CORDIC_STEPS)
   ) u_pitch (
      .clock     (clock),
      .reset     (reset),
      .en        (back_en),
      .in_valid  (m_valid),
      .in_y      (TW'(m_gy)),
      .in_x      (signed'(TW'(m_mp))),
      .out_valid (pitch_v),
      .angle     (rsp_bus.pitch_angle)
   );

   qtypr_cordic #(
      .W (TW), .ANGLE_BITS (ANGLE_BITS), .CORDIC_STEPS (CORDIC_STEPS)
   ) u_roll (
      .clock     (clock),
      .reset     (reset),
      .en        (back_en),
      .in_valid  (m_valid),
      .in_y      (TW'(m_gx)),
      .in_x      (signed'(TW'(m_mr))),
      .out_valid (roll_v),
      .angle     (rsp_bus.roll_angle)
   );

   // the three angle pipes run in lockstep
   assign rsp_bus.valid = yaw_v && pitch_v && roll_v;
endmodule

@@ hdl/qtypr_queue.sv @@
module qtypr_queue #(
   parameter int W = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [W-1:0]                 push_data,
   input  logic                         pop,
   output logic [W-1:0]                 pop_data,
   output qtypr_pkg::qtypr_q_status_type status
);
   localparam int PTR_BITS = $clog2(qtypr_pkg::QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(qtypr_pkg::QUEUE_DEPTH + 1);

   logic [W-1:0]        data_ff [qtypr_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_BITS'(push) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = data_ff[rd_ptr_ff];
   assign status.full  = (cnt_ff == CNT_BITS'(qtypr_pkg::QUEUE_DEPTH));
   assign status.empty = (cnt_ff == '0);
endmodule

@@ hdl/qtypr_front.sv @@
module qtypr_front #(
   parameter int QUAT_FRAC_BITS = 14,
   parameter int YD_BITS        = 35
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic signed [15:0]                  quat_w,
   input  logic signed [15:0]                  quat_x,
   input  logic signed [15:0]                  quat_y,
   input  logic signed [15:0]                  quat_z,
   output logic                                out_valid,
   output logic signed [qtypr_pkg::G_BITS-1:0] gx,
   output logic signed [qtypr_pkg::G_BITS-1:0] gy,
   output logic signed [qtypr_pkg::YN_BITS-1:0] yn,
   output logic signed [YD_BITS-1:0]           yd,
   output logic [qtypr_pkg::SQ_BITS-1:0]       sp,
   output logic [qtypr_pkg::SQ_BITS-1:0]       sr
);
   localparam int GB = qtypr_pkg::G_BITS;
   localparam int AB = qtypr_pkg::ABS_BITS;
   localparam int NB = qtypr_pkg::YN_BITS;
   localparam int SB = qtypr_pkg::SQ_BITS;
   localparam logic signed [YD_BITS-1:0] YD_ONE =
      YD_BITS'(64'd1 << (2 * QUAT_FRAC_BITS));

   logic [3:0] v_ff, v_in;

   // stage 1: products
   logic signed [31:0] ww_ff, xx_ff, yy_ff, zz_ff, xz_ff, wy_ff, wx_ff, yz_ff,
                       xy_ff, wz_ff;
   // stage 2: gravity and yaw terms
   logic signed [32:0] dgx, dgy;
   logic signed [33:0] sgz;
   logic signed [GB-1:0] gx2_in, gy2_in, gz2_in;
   logic signed [GB-1:0] gx2_ff, gy2_ff;
   logic [AB-1:0] ax2_ff, ay2_ff, az2_ff;
   logic signed [NB-1:0] yn2_ff, yn3_ff;
   logic signed [YD_BITS-1:0] yd2_ff, yd3_ff;
   // stage 3: squares
   logic signed [GB-1:0] gx3_ff, gy3_ff;
   logic [SB-3:0] qx_ff, qy_ff, qz_ff;
   // stage 4: sums
   logic signed [GB-1:0] gx4_ff, gy4_ff;
   logic signed [NB-1:0] yn4_ff;
   logic signed [YD_BITS-1:0] yd4_ff;
   logic [SB-1:0] sp_ff, sr_ff;

   assign v_in = {v_ff[2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_comb begin
      dgx    = 33'(xz_ff) - 33'(wy_ff);
      dgy    = 33'(wx_ff) + 33'(yz_ff);
      sgz    = 34'(ww_ff) - 34'(xx_ff) - 34'(yy_ff) + 34'(zz_ff);
      // divide by four, truncating toward zero
      gx2_in = GB'(dgx[32] ? (dgx + 33'sd1) >>> 1 : dgx >>> 1);
      gy2_in = GB'(dgy[32] ? (dgy + 33'sd1) >>> 1 : dgy >>> 1);
      gz2_in = GB'(sgz[33] ? (sgz + 34'sd3) >>> 2 : sgz >>> 2);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ww_ff  <= quat_w * quat_w;
         xx_ff  <= quat_x * quat_x;
         yy_ff  <= quat_y * quat_y;
         zz_ff  <= quat_z * quat_z;
         xz_ff  <= quat_x * quat_z;
         wy_ff  <= quat_w * quat_y;
         wx_ff  <= quat_w * quat_x;
         yz_ff  <= quat_y * quat_z;
         xy_ff  <= quat_x * quat_y;
         wz_ff  <= quat_w * quat_z;

         gx2_ff <= gx2_in;
         gy2_ff <= gy2_in;
         ax2_ff <= AB'(gx2_in[GB-1] ? -gx2_in : gx2_in);
         ay2_ff <= AB'(gy2_in[GB-1] ? -gy2_in : gy2_in);
         az2_ff <= AB'(gz2_in[GB-1] ? -gz2_in : gz2_in);
         yn2_ff <= (NB'(xy_ff) - NB'(wz_ff)) <<< 1;
         yd2_ff <= ((YD_BITS'(ww_ff) + YD_BITS'(xx_ff)) <<< 1) - YD_ONE;

         gx3_ff <= gx2_ff;
         gy3_ff <= gy2_ff;
         yn3_ff <= yn2_ff;
         yd3_ff <= yd2_ff;
         qx_ff  <= (SB-2)'(ax2_ff) * (SB-2)'(ax2_ff);
         qy_ff  <= (SB-2)'(ay2_ff) * (SB-2)'(ay2_ff);
         qz_ff  <= (SB-2)'(az2_ff) * (SB-2)'(az2_ff);

         gx4_ff <= gx3_ff;
         gy4_ff <= gy3_ff;
         yn4_ff <= yn3_ff;
         yd4_ff <= yd3_ff;
         sp_ff  <= SB'(qx_ff) + SB'(qz_ff);
         sr_ff  <= SB'(qy_ff) + SB'(qz_ff);
      end
   end

   assign out_valid = v_ff[3];
   assign gx = gx4_ff;
   assign gy = gy4_ff;
   assign yn = yn4_ff;
   assign yd = yd4_ff;
   assign sp = sp_ff;
   assign sr = sr_ff;
endmodule

@@ hdl/qtypr_mag.sv @@
module qtypr_mag #(
   parameter int YD_BITS = 35
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic signed [qtypr_pkg::G_BITS-1:0]  in_gx,
   input  logic signed [qtypr_pkg::G_BITS-1:0]  in_gy,
   input  logic signed [qtypr_pkg::YN_BITS-1:0] in_yn,
   input  logic signed [YD_BITS-1:0]            in_yd,
   input  logic [qtypr_pkg::SQ_BITS-1:0]        in_sp,
   input  logic [qtypr_pkg::SQ_BITS-1:0]        in_sr,
   output logic                                 out_valid,
   output logic signed [qtypr_pkg::G_BITS-1:0]  out_gx,
   output logic signed [qtypr_pkg::G_BITS-1:0]  out_gy,
   output logic signed [qtypr_pkg::YN_BITS-1:0] out_yn,
   output logic signed [YD_BITS-1:0]            out_yd,
   output logic [qtypr_pkg::ROOT_BITS-1:0]      out_mp,
   output logic [qtypr_pkg::ROOT_BITS-1:0]      out_mr
);
   localparam int RB = qtypr_pkg::ROOT_BITS;
   localparam int SB = qtypr_pkg::SQ_BITS;

   logic [RB-1:0]              v_ff;
   logic signed [qtypr_pkg::G_BITS-1:0]  gx_ff [RB];
   logic signed [qtypr_pkg::G_BITS-1:0]  gy_ff [RB];
   logic signed [qtypr_pkg::YN_BITS-1:0] yn_ff [RB];
   logic signed [YD_BITS-1:0]  yd_ff [RB];
   logic [SB-1:0]              remp_ff [RB];
   logic [SB-1:0]              remr_ff [RB];
   logic [RB-1:0]              rootp_ff [RB];
   logic [RB-1:0]              rootr_ff [RB];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[RB-2:0], in_valid};
      end
   end

   // one root bit per stage, most significant first
   for (genvar k = 0; k < RB; k++) begin : g_stage
      localparam int B = RB - 1 - k;
      logic [SB-1:0] remp_src, remr_src, dp, dr;
      logic [RB-1:0] rootp_src, rootr_src;
      logic signed [qtypr_pkg::G_BITS-1:0]  gx_src, gy_src;
      logic signed [qtypr_pkg::YN_BITS-1:0] yn_src;
      logic signed [YD_BITS-1:0] yd_src;

      if (k == 0) begin : g_first
         assign remp_src  = in_sp;
         assign remr_src  = in_sr;
         assign rootp_src = '0;
         assign rootr_src = '0;
         assign gx_src    = in_gx;
         assign gy_src    = in_gy;
         assign yn_src    = in_yn;
         assign yd_src    = in_yd;
      end else begin : g_next
         assign remp_src  = remp_ff[k-1];
         assign remr_src  = remr_ff[k-1];
         assign rootp_src = rootp_ff[k-1];
         assign rootr_src = rootr_ff[k-1];
         assign gx_src    = gx_ff[k-1];
         assign gy_src    = gy_ff[k-1];
         assign yn_src    = yn_ff[k-1];
         assign yd_src    = yd_ff[k-1];
      end

      assign dp = (SB'(rootp_src) << (B + 1)) | (SB'(1) << (2 * B));
      assign dr = (SB'(rootr_src) << (B + 1)) | (SB'(1) << (2 * B));

      always_ff @(posedge clock) begin
         if (en) begin
            gx_ff[k] <= gx_src;
            gy_ff[k] <= gy_src;
            yn_ff[k] <= yn_src;
            yd_ff[k] <= yd_src;
            if (remp_src >= dp) begin
               remp_ff[k]  <= remp_src - dp;
               rootp_ff[k] <= rootp_src | (RB'(1) << B);
            end else begin
               remp_ff[k]  <= remp_src;
               rootp_ff[k] <= rootp_src;
            end
            if (remr_src >= dr) begin
               remr_ff[k]  <= remr_src - dr;
               rootr_ff[k] <= rootr_src | (RB'(1) << B);
            end else begin
               remr_ff[k]  <= remr_src;
               rootr_ff[k] <= rootr_src;
            end
         end
      end
   end

   assign out_valid = v_ff[RB-1];
   assign out_gx    = gx_ff[RB-1];
   assign out_gy    = gy_ff[RB-1];
   assign out_yn    = yn_ff[RB-1];
   assign out_yd    = yd_ff[RB-1];
   assign out_mp    = rootp_ff[RB-1];
   assign out_mr    = rootr_ff[RB-1];
endmodule

@@ hdl/qtypr_cordic.sv @@
module qtypr_cordic #(
   parameter int W            = 35,
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic signed [W-1:0] in_y,
   input  logic signed [W-1:0] in_x,
   output logic                out_valid,
   output logic signed [15:0]  angle
);
   localparam int STEPS = (CORDIC_STEPS > qtypr_pkg::MAX_STEPS) ?
                          qtypr_pkg::MAX_STEPS : CORDIC_STEPS;
   localparam int SH = 32 - ANGLE_BITS;
   localparam logic [32:0] HALF = (33'd1 << SH) >> 1;

   logic [STEPS+1:0]    v_ff;
   logic signed [W-1:0] x_ff [STEPS+1];
   logic signed [W-1:0] y_ff [STEPS+1];
   logic [31:0]         z_ff [STEPS+1];
   logic                fix_ff [STEPS+1];
   logic signed [15:0]  angle_ff;

   logic signed [W-1:0] x0_in, y0_in;
   logic [31:0]         z0_in;
   logic                fix0_in;
   logic                x_neg, y_pos, y_neg;
   logic [32:0]         rnd;
   logic [ANGLE_BITS-1:0] ang_r;
   logic signed [31:0]  ang_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[STEPS:0], in_valid};
      end
   end

   // pre-rotation into the right half plane, axis cases settled here
   always_comb begin
      x_neg   = in_x[W-1];
      y_neg   = in_y[W-1];
      y_pos   = !in_y[W-1] && (in_y != '0);
      x0_in   = in_x;
      y0_in   = in_y;
      z0_in   = '0;
      fix0_in = 1'b0;
      priority if (in_x == '0) begin
         fix0_in = 1'b1;
         z0_in   = y_pos ? qtypr_pkg::QUARTER_TURN :
                   (y_neg ? 32'h0 - qtypr_pkg::QUARTER_TURN : 32'h0);
      end else if (in_y == '0) begin
         fix0_in = 1'b1;
         z0_in   = x_neg ? qtypr_pkg::HALF_TURN : 32'h0;
      end else if (x_neg) begin
         if (y_pos) begin
            x0_in = in_y;
            y0_in = -in_x;
            z0_in = qtypr_pkg::QUARTER_TURN;
         end else begin
            x0_in = -in_y;
            y0_in = in_x;
            z0_in = 32'h0 - qtypr_pkg::QUARTER_TURN;
         end
      end else begin
         x0_in = in_x;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]   <= x0_in;
         y_ff[0]   <= y0_in;
         z_ff[0]   <= z0_in;
         fix_ff[0] <= fix0_in;
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic signed [W-1:0] xs, ys;
      logic                up;
      assign xs = x_ff[k] >>> k;
      assign ys = y_ff[k] >>> k;
      assign up = !y_ff[k][W-1] && (y_ff[k] != '0);

      always_ff @(posedge clock) begin
         if (en) begin
            fix_ff[k+1] <= fix_ff[k];
            if (up) begin
               x_ff[k+1] <= x_ff[k] + ys;
               y_ff[k+1] <= y_ff[k] - xs;
               z_ff[k+1] <= fix_ff[k] ? z_ff[k] : z_ff[k] + qtypr_pkg::ATAN_TAB[k];
            end else begin
               x_ff[k+1] <= x_ff[k] - ys;
               y_ff[k+1] <= y_ff[k] + xs;
               z_ff[k+1] <= fix_ff[k] ? z_ff[k] : z_ff[k] - qtypr_pkg::ATAN_TAB[k];
            end
         end
      end
   end

   // round half up to the angle width, then sign extend
   always_comb begin
      rnd     = {1'b0, z_ff[STEPS]} + HALF;
      ang_r   = rnd[SH +: ANGLE_BITS];
      ang_ext = 32'(signed'(ang_r));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= ang_ext[15:0];
      end
   end

   assign out_valid = v_ff[STEPS+1];
   assign angle     = angle_ff;
endmodule

@@ hdl/qtypr_checker.sv @@
`include "quaternion_to_yaw_pitch_roll_defines.svh"

module qtypr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] yaw,
   input logic [15:0] pitch,
   input logic [15:0] roll
);
   logic [7:0] cnt_ff, cnt_in;

   assign cnt_in = cnt_ff + 8'(req_valid && req_ready) - 8'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   `QTYPR_ASSERT_IMP(a_no_orphan, rsp_valid, cnt_ff != 8'd0, "result word with no word in flight")
   `QTYPR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(yaw) && $stable(pitch) && $stable(roll), "stalled result word changed")
   `QTYPR_ASSERT_ALWAYS(a_reset_empty, reset, !rsp_valid, "result valid right after reset")
endmodule

bind quaternion_to_yaw_pitch_roll qtypr_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .yaw       (rsp_bus.yaw_angle),
   .pitch     (rsp_bus.pitch_angle),
   .roll      (rsp_bus.roll_angle)
);

@@ tb/sv/quaternion_to_yaw_pitch_roll_checker.sv @@
module quaternion_to_yaw_pitch_roll_checker (
   input  logic        clock,
   input  logic        reset,
   qtypr_req_if        req_bus,
   qtypr_rsp_if        rsp_bus,
   output int          failures,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS = 14;
   localparam int ANG_BITS  = 16;
   localparam int STEPS     = 16;

   typedef struct packed {
      logic [15:0] yaw;
      logic [15:0] pitch;
      logic [15:0] roll;
   } angles_t;

   angles_t angles_due [$];

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // Vectoring CORDIC; angle accumulator wraps at 2^32.
   function automatic logic [31:0] vector_angle(longint num, longint den);
      logic [31:0] acc;
      longint t, xs, ys;
      acc = '0;
      if (den == 0)
         return num > 0 ? qtypr_pkg::QUARTER_TURN :
                (num < 0 ? -qtypr_pkg::QUARTER_TURN : 32'd0);
      if (num == 0) return den > 0 ? 32'd0 : qtypr_pkg::HALF_TURN;
      if (den < 0) begin
         if (num > 0) begin
            t = den; den = num; num = -t; acc = qtypr_pkg::QUARTER_TURN;
         end else begin
            t = den; den = -num; num = t; acc = -qtypr_pkg::QUARTER_TURN;
         end
      end
      for (int i = 0; i < STEPS; i++) begin
         xs = den >>> i;
         ys = num >>> i;
         if (num > 0) begin
            den += ys; num -= xs; acc += qtypr_pkg::ATAN_TAB[i];
         end else begin
            den -= ys; num += xs; acc -= qtypr_pkg::ATAN_TAB[i];
         end
      end
      return acc;
   endfunction

   function automatic logic [15:0] round_angle(logic [31:0] a);
      logic [32:0] v;
      v = ({1'b0, a} + (33'd1 << (31 - ANG_BITS))) >> (32 - ANG_BITS);
      return v[15:0];
   endfunction

   function automatic angles_t euler_of(longint w, longint x, longint y, longint z);
      longint one, gx, gy, gz, yn, yd;
      longint unsigned mp, mr;
      angles_t r;
      one = longint'(1) << (2 * FRAC_BITS);
      gx = (2 * (x * z - w * y)) / 4;
      gy = (2 * (w * x + y * z)) / 4;
      gz = (w * w - x * x - y * y + z * z) / 4;
      yn = 2 * x * y - 2 * w * z;
      yd = 2 * w * w + 2 * x * x - one;
      mp = int_sqrt(longint'(gx * gx) + longint'(gz * gz));
      mr = int_sqrt(longint'(gy * gy) + longint'(gz * gz));
      r.yaw   = round_angle(vector_angle(yn, yd));
      r.pitch = round_angle(vector_angle(gy, longint'(mp)));
      r.roll  = round_angle(vector_angle(gx, longint'(mr)));
      return r;
   endfunction

   assign pending = angles_due.size();

   always @(posedge clock) begin
      angles_t seen, want;
      if (reset) begin
         angles_due.delete();
         failures <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen = {rsp_bus.yaw_angle, rsp_bus.pitch_angle, rsp_bus.roll_angle};
            if (angles_due.size() == 0) begin
               $error("unexpected word yaw=%0d pitch=%0d roll=%0d",
                      $signed(seen.yaw), $signed(seen.pitch), $signed(seen.roll));
               failures <= failures + 1;
            end else begin
               want = angles_due.pop_front();
               if (seen.yaw !== want.yaw)
                  $error("yaw_angle expected %0d actual %0d",
                         $signed(want.yaw), $signed(seen.yaw));
               if (seen.pitch !== want.pitch)
                  $error("pitch_angle expected %0d actual %0d",
                         $signed(want.pitch), $signed(seen.pitch));
               if (seen.roll !== want.roll)
                  $error("roll_angle expected %0d actual %0d",
                         $signed(want.roll), $signed(seen.roll));
               if (seen !== want) failures <= failures + 1;
            end
         end
         if (req_bus.valid && req_bus.ready)
            angles_due.push_back(euler_of(req_bus.quat_w, req_bus.quat_x,
                                          req_bus.quat_y, req_bus.quat_z));
      end
   end
endmodule

@@ tb/sv/quaternion_to_yaw_pitch_roll_test.sv @@
module quaternion_to_yaw_pitch_roll_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WORDS = 1000;
   localparam int IDLE_LIMIT   = 5000;
   // Drain margin covers the pipeline described in the block header.
   localparam int DRAIN_CYCLES = 60;

   logic clock;
   logic reset;
   int   failures;
   int   pending;
   int   idle_cycles;
   bit   long_hold;
   bit   timed_out;

   qtypr_req_if req_bus ();
   qtypr_rsp_if rsp_bus ();

   quaternion_to_yaw_pitch_roll dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   quaternion_to_yaw_pitch_roll_checker checker_i (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .failures (failures),
      .pending  (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: count cycles with no word moving on either side.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("quaternion_to_yaw_pitch_roll_test NOT OK");
         $finish;
      end
   end

   // Receiver: stall on its own pattern. Mode is redrawn now and then at
   // random; a long hold is requested by the stimulus process.
   initial begin
      int mode;
      int hold;
      rsp_bus.ready <= 1'b0;
      mode = 0;
      @(posedge clock iff !reset);
      forever begin
         if (long_hold) begin
            // Hold ready low long enough to fill the pipeline and the queue.
            rsp_bus.ready <= 1'b0;
            hold = 200;
            repeat (hold) @(posedge clock);
            long_hold = 1'b0;
         end
         if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 2);
         case (mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         endcase
         @(posedge clock);
      end
   end

   // Drive one word and hold it until accepted.
   task automatic send_word(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                            logic [15:0] z);
      req_bus.valid  <= 1'b1;
      req_bus.quat_w <= w;
      req_bus.quat_x <= x;
      req_bus.quat_y <= y;
      req_bus.quat_z <= z;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic idle_gap(int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_component();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'(-16384);
      if (r == 1) return 16'(16384);
      if (r == 2) return 16'($urandom_range(0, 8) - 4);
      if (r == 3) return 16'($urandom); // out of range, all bits toggle
      return 16'($urandom_range(0, 32768) - 16384);
   endfunction

   initial begin
      int burst;
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.quat_w = '0;
      req_bus.quat_x = '0;
      req_bus.quat_y = '0;
      req_bus.quat_z = '0;
      long_hold      = 1'b0;
      timed_out      = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words: identity, axis turns, zero quaternion (0/0 cases),
      // extremes, negative yaw denominator, out-of-range values.
      send_word(16'd16384, 16'd0, 16'd0, 16'd0);
      send_word(-16'd16384, 16'd0, 16'd0, 16'd0);
      send_word(16'd0, 16'd0, 16'd0, 16'd0);
      send_word(16'd0, 16'd16384, 16'd0, 16'd0);
      send_word(16'd0, 16'd0, 16'd16384, 16'd0);
      send_word(16'd0, 16'd0, 16'd0, 16'd16384);
      send_word(16'd11585, 16'd0, 16'd0, 16'd11585);
      send_word(16'd11585, 16'd0, 16'd0, -16'd11585);
      send_word(16'd11585, 16'd11585, 16'd0, 16'd0);
      send_word(16'd11585, 16'd0, 16'd11585, 16'd0);
      send_word(16'd11585, 16'd0, -16'd11585, 16'd0);
      send_word(16'd8192, 16'd8192, 16'd8192, 16'd8192);
      send_word(-16'd16384, -16'd16384, -16'd16384, -16'd16384);
      send_word(16'd16384, 16'd16384, 16'd16384, 16'd16384);
      send_word(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
      send_word(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(16'd1, 16'd0, 16'd0, 16'd0);
      send_word(16'd0, 16'd1, 16'd1, 16'd0);

      // Pause until every expected word has arrived.
      idle_gap(1);
      while (pending != 0) @(posedge clock);

      for (int n = 0; n < RANDOM_WORDS; ) begin
         burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
         for (int b = 0; b < burst && n < RANDOM_WORDS; b++, n++) begin
            // Ask for a long receiver hold once, mid-run, while offering words.
            if (n == RANDOM_WORDS / 2) long_hold = 1'b1;
            send_word(pick_component(), pick_component(), pick_component(),
                      pick_component());
         end
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
      end
      req_bus.valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("quaternion_to_yaw_pitch_roll_test OK");
      else
         $display("quaternion_to_yaw_pitch_roll_test NOT OK");
      $finish;
   end
endmodule
